FILE: rtl/core/mhrb_pkg.sv
package mhrb_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } mhrb_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_FETCH,
    S_EMIT
  } mhrb_state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;
    logic capture;
    logic setup;
    logic fetch;
    logic advance;
  } mhrb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } mhrb_stat_t;

endpackage

FILE: rtl/core/mhrb_if.sv
interface mhrb_req_if import mhrb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [CHAN_W-1:0]     channel;
  logic [SAMPLE_W-1:0]   sample;
  logic [COUNT_W-1:0]    read_count;

  modport source (output valid, cmd, channel, sample, read_count, input ready);
  modport sink   (input valid, cmd, channel, sample, read_count, output ready);
endinterface

interface mhrb_rsp_if import mhrb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SAMPLE_W-1:0]   sample_out;
  logic                  sample_valid;
  logic                  last;
  logic [COUNT_W-1:0]    returned_count;

  modport source (output valid, sample_out, sample_valid, last, returned_count, input ready);
  modport sink   (input valid, sample_out, sample_valid, last, returned_count, output ready);
endinterface

FILE: rtl/core/multichannel_history_ring_buffer.sv
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    cmd, channel, sample, read_count
// rsp      out  valid/ready    sample_out, sample_valid, last, returned_count
//
// A write request is taken while idle; writes are taken back to back.
// A read request is captured and set up, then each returned sample takes a
// memory read step and a result step; an empty read gives one result.
// The single-port sample memory with registered read sets the per-sample pace.
// Reset (rst, synchronous) clears the controller state, write pointers and fill counts only.
// A stalled result holds until rsp.ready; no request is taken during a read.
module multichannel_history_ring_buffer import mhrb_pkg::*; #(
  parameter int unsigned FRAMES   = 1024,
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned MAX_READ = 64
) (
  input logic        clk,
  input logic        rst,
  mhrb_req_if.sink   req,
  mhrb_rsp_if.source rsp
);

  mhrb_cmd_t  cmd;
  mhrb_stat_t stat;

  mhrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_cmd    (req.cmd),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mhrb_dp #(
    .FRAMES   (FRAMES),
    .CHANNELS (CHANNELS),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .channel        (req.channel),
    .sample         (req.sample),
    .read_count     (req.read_count),
    .sample_out     (rsp.sample_out),
    .sample_valid   (rsp.sample_valid),
    .last           (rsp.last),
    .returned_count (rsp.returned_count)
  );

endmodule

FILE: rtl/core/mhrb_ctrl.sv
module mhrb_ctrl import mhrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mhrb_stat_t stat,
  output mhrb_cmd_t  cmd
);

  mhrb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && (in_cmd == CMD_READ)) state_next = S_SETUP;
      end
      S_SETUP: state_next = S_FETCH;
      S_FETCH: state_next = S_EMIT;
      S_EMIT: begin
        if (out_ready) state_next = stat.last ? S_IDLE : S_FETCH;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.wr_en   = in_valid && (in_cmd == CMD_WRITE);
        cmd.capture = in_valid && (in_cmd == CMD_READ);
      end
      S_SETUP: cmd.setup = 1'b1;
      S_FETCH: cmd.fetch = 1'b1;
      S_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !stat.last;
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_next_fetch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !stat.last |=> state == S_FETCH)
    else $error("read did not continue after a non-final result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && stat.last |=> in_ready)
    else $error("controller not idle after final result");

endmodule

FILE: rtl/core/mhrb_dp.sv
module mhrb_dp import mhrb_pkg::*; #(
  parameter int unsigned FRAMES   = 1024,
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  mhrb_cmd_t           cmd,
  output mhrb_stat_t          stat,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [COUNT_W-1:0]  read_count,
  output logic [SAMPLE_W-1:0] sample_out,
  output logic                sample_valid,
  output logic                last,
  output logic [COUNT_W-1:0]  returned_count
);

  localparam int unsigned FW     = $clog2(FRAMES);
  localparam int unsigned FCW    = $clog2(FRAMES + 1);
  localparam int unsigned CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW     = CW + FW;
  localparam int unsigned SW     = FW + 1;
  localparam int unsigned MW     = (FCW > COUNT_W) ? FCW : COUNT_W;
  localparam logic [CHAN_W:0]    CH_LIMIT   = (CHAN_W + 1)'(CHANNELS);
  localparam logic [FW-1:0]      IDX_LAST   = FW'(FRAMES - 1);
  localparam logic [FCW-1:0]     FILL_FULL  = FCW'(FRAMES);
  localparam logic [SW-1:0]      FRAMES_X   = SW'(FRAMES);
  localparam logic [MW-1:0]      MAXR_X     = MW'(MAX_READ);

  logic [FW-1:0]       wr_ptr [CHANNELS];
  logic [FCW-1:0]      fill   [CHANNELS];
  logic [SAMPLE_W-1:0] store  [2**AW];

  logic [CHAN_W-1:0]   ch_q;
  logic [COUNT_W-1:0]  req_q;
  logic [COUNT_W-1:0]  n_q;
  logic [COUNT_W-1:0]  pos_q;
  logic [FW-1:0]       idx_q;
  logic                empty_q;
  logic [SAMPLE_W-1:0] rd_data;

  logic                wr_ok;
  logic [CW-1:0]       wr_ch;
  logic [FW-1:0]       wr_ptr_cur;
  logic [CW-1:0]       rd_ch;
  logic                rd_ok;
  logic [MW-1:0]       fill_x;
  logic [MW-1:0]       req_x;
  logic [MW-1:0]       n_x;
  logic [SW-1:0]       wp_x;
  logic [SW-1:0]       n_s;
  logic [SW-1:0]       start_x;

  assign wr_ok      = ({1'b0, channel} < CH_LIMIT);
  assign wr_ch      = channel[CW-1:0];
  assign wr_ptr_cur = wr_ptr[wr_ch];

  assign rd_ok = ({1'b0, ch_q} < CH_LIMIT);
  assign rd_ch = ch_q[CW-1:0];

  // clamp to MAX_READ, then to the fill count; back up from the write pointer
  always_comb begin
    fill_x = MW'(fill[rd_ch]);
    req_x  = MW'(req_q);
    if (req_x > MAXR_X) req_x = MAXR_X;
    n_x  = (fill_x < req_x) ? fill_x : req_x;
    if (!rd_ok) n_x = '0;
    wp_x = {1'b0, wr_ptr[rd_ch]};
    n_s  = SW'(n_x);
    if (wp_x >= n_s) begin
      start_x = wp_x - n_s;
    end else begin
      start_x = wp_x + FRAMES_X - n_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
    end else if (cmd.wr_en && wr_ok) begin
      wr_ptr[wr_ch] <= (wr_ptr_cur == IDX_LAST) ? '0 : wr_ptr_cur + 1'b1;
      if (fill[wr_ch] < FILL_FULL) fill[wr_ch] <= fill[wr_ch] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      store[{wr_ch, wr_ptr_cur}] <= sample;
    end
    if (cmd.fetch) begin
      rd_data <= store[{rd_ch, idx_q}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_q  <= channel;
      req_q <= read_count;
    end
    if (cmd.setup) begin
      n_q     <= n_x[COUNT_W-1:0];
      empty_q <= (n_x == '0);
      idx_q   <= start_x[FW-1:0];
      pos_q   <= '0;
    end
    if (cmd.advance) begin
      idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
      pos_q <= pos_q + 1'b1;
    end
  end

  assign last           = empty_q || (pos_q + 1'b1 == n_q);
  assign stat.last      = last;
  assign sample_valid   = !empty_q;
  assign sample_out     = empty_q ? '0 : rd_data;
  assign returned_count = empty_q ? '0 : n_q;

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en && wr_ok |=> fill[$past(wr_ch)] != '0)
    else $error("fill count zero after a write");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> !empty_q && (pos_q + 1'b1 < n_q))
    else $error("advance past the end of a read");

  a_setup_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.setup |=> n_q <= COUNT_W'(MAX_READ))
    else $error("returned count above read limit");

endmodule
